>>> hdl/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types and constants for greedy activity selection (latest start first).
// ----------------------------------------------------------------------------
package asl_pkg;

	localparam int MAX_ACTIVITIES_DEF = 32;
	localparam int TIME_BITS_DEF      = 16;
	localparam int MAX_ACT_LIMIT      = 64;

	localparam int FIELD_TIME_W = 16;
	localparam int NUM_W        = 5;
	localparam int CMD_CNT_W    = $clog2(MAX_ACT_LIMIT + 1);
	localparam int CMD_DEPTH    = 2;

	typedef struct packed {
		logic [FIELD_TIME_W-1:0] start_time;
		logic [FIELD_TIME_W-1:0] finish_time;
		logic                    final_item;
	} item_t;

	typedef struct packed {
		logic [NUM_W-1:0] activity_number;
		logic             last_selected;
		logic             overflowed;
	} result_t;

	// run request handed from the loader to the selector
	typedef struct packed {
		logic [CMD_CNT_W-1:0] count;
		logic                 overflow;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_EMIT_RD,
		ST_EMIT
	} back_state_t;

endpackage

>>> hdl/activity_selection_latest_start.sv
// ----------------------------------------------------------------------------
// activity_selection_latest_start
// Greedy activity selection from the latest start: loads a set of activities,
// then emits the kept activity numbers in ascending start order.
// ----------------------------------------------------------------------------
// Channel  | Signals                 | Transfer
// ---------+-------------------------+-----------------------------------
// input    | start, busy, item       | edge with start high, busy low
// result   | strobe, result          | every cycle strobe is high
//
// The loader accepts one activity per cycle while busy is low. After the final
// item, the selector picks up the run request, then makes one pass over the
// time stores (scan, drain, decide) for each kept activity plus one empty pass,
// then reads each result from the stack and emits it.
// busy stays high from the final item until the last result has gone out.
// Reset clears counts and control; the stores need no clearing.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module activity_selection_latest_start #(
	parameter int MAX_ACTIVITIES = asl_pkg::MAX_ACTIVITIES_DEF,
	parameter int TIME_BITS      = asl_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  asl_pkg::item_t   item,
	output logic             strobe,
	output asl_pkg::result_t result
);
	import asl_pkg::*;

	localparam int IDX_W = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;

	logic                 we;
	logic [IDX_W-1:0]     waddr;
	logic [TIME_BITS-1:0] wstart;
	logic [TIME_BITS-1:0] wfinish;
	logic                 push;
	cmd_t                 push_cmd;
	cmd_t                 pop_cmd;
	logic                 cmd_empty;
	logic                 cmd_pop;
	logic [IDX_W-1:0]     rd_addr;
	logic [TIME_BITS-1:0] rd_start;
	logic [TIME_BITS-1:0] rd_finish;
	logic                 back_active;

	assign busy = ~cmd_empty | back_active;

	asl_front #(
		.MAX_ACTIVITIES (MAX_ACTIVITIES),
		.TIME_BITS      (TIME_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.we      (we),
		.waddr   (waddr),
		.wstart  (wstart),
		.wfinish (wfinish),
		.push    (push),
		.cmd     (push_cmd)
	);

	asl_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_ACTIVITIES)
	) u_start_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wstart),
		.raddr (rd_addr),
		.rdata (rd_start)
	);

	asl_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_ACTIVITIES)
	) u_finish_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wfinish),
		.raddr (rd_addr),
		.rdata (rd_finish)
	);

	asl_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (cmd_pop),
		.pop_data  (pop_cmd),
		.empty     (cmd_empty)
	);

	asl_back #(
		.MAX_ACTIVITIES (MAX_ACTIVITIES),
		.TIME_BITS      (TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.rd_addr   (rd_addr),
		.rd_start  (rd_start),
		.rd_finish (rd_finish),
		.active    (back_active),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

>>> hdl/asl_ram.sv
// ----------------------------------------------------------------------------
// asl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hdl/asl_front.sv
// ----------------------------------------------------------------------------
// asl_front
// Loader: takes activities, writes the time stores, tracks count and overflow,
// and posts a run request when the final item arrives.
// ----------------------------------------------------------------------------
module asl_front #(
	parameter int MAX_ACTIVITIES = 32,
	parameter int TIME_BITS      = 16,
	localparam int IDX_W         = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1,
	localparam int CNT_W         = $clog2(MAX_ACTIVITIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  asl_pkg::item_t       item,
	output logic                 we,
	output logic [IDX_W-1:0]     waddr,
	output logic [TIME_BITS-1:0] wstart,
	output logic [TIME_BITS-1:0] wfinish,
	output logic                 push,
	output asl_pkg::cmd_t        cmd
);
	import asl_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             accept;
	logic             has_room;
	logic [CNT_W-1:0] count_after;
	logic             ovf_after;

	assign accept      = start & ~busy;
	assign has_room    = (count_q < CNT_W'(MAX_ACTIVITIES));
	assign count_after = has_room ? count_q + CNT_W'(1) : count_q;
	assign ovf_after   = ovf_q | ~has_room;

	assign we      = accept & has_room;
	assign waddr   = count_q[IDX_W-1:0];
	assign wstart  = TIME_BITS'(item.start_time);
	assign wfinish = TIME_BITS'(item.finish_time);

	assign push         = accept & item.final_item;
	assign cmd.count    = CMD_CNT_W'(count_after);
	assign cmd.overflow = ovf_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (item.final_item) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_after;
				ovf_q   <= ovf_after;
			end
		end
	end

endmodule

>>> hdl/asl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// asl_cmd_fifo
// Two-entry queue of run requests between loader and selector.
// ----------------------------------------------------------------------------
module asl_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  asl_pkg::cmd_t push_data,
	input  logic          pop,
	output asl_pkg::cmd_t pop_data,
	output logic          empty
);
	import asl_pkg::*;

	localparam int PW = $clog2(CMD_DEPTH);
	localparam int CW = $clog2(CMD_DEPTH + 1);

	cmd_t          mem_q [CMD_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          full;
	logic          do_push;
	logic          do_pop;

	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q == CW'(CMD_DEPTH));
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/asl_back.sv
// ----------------------------------------------------------------------------
// asl_back
// Selector: one pass over the stores per kept activity finds the next one in
// visit order that fits; kept numbers go on a stack and are emitted reversed.
// ----------------------------------------------------------------------------
module asl_back #(
	parameter int MAX_ACTIVITIES = 32,
	parameter int TIME_BITS      = 16,
	localparam int IDX_W         = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1,
	localparam int CNT_W         = $clog2(MAX_ACTIVITIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  asl_pkg::cmd_t        cmd,
	input  logic                 cmd_empty,
	output logic                 cmd_pop,
	output logic [IDX_W-1:0]     rd_addr,
	input  logic [TIME_BITS-1:0] rd_start,
	input  logic [TIME_BITS-1:0] rd_finish,
	output logic                 active,
	output logic                 strobe,
	output asl_pkg::result_t     result
);
	import asl_pkg::*;

	back_state_t state_q, state_nxt;

	logic [CNT_W-1:0]     n_q;
	logic                 ovf_q;
	logic                 first_q;
	logic [IDX_W-1:0]     scan_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TIME_BITS-1:0] best_start_q;
	logic [IDX_W-1:0]     cur_idx_q;
	logic [TIME_BITS-1:0] cur_start_q;
	logic [CNT_W-1:0]     kept_q;
	logic [CNT_W-1:0]     top_ptr;
	logic                 last_issue;
	logic                 after_cur;
	logic                 elig;
	logic                 take;
	logic                 stk_we;
	logic [IDX_W-1:0]     stk_rdata;

	assign last_issue = (CNT_W'(scan_q) == n_q - CNT_W'(1));
	assign top_ptr    = kept_q - CNT_W'(1);

	// visit order: start descending, lower index first on equal start
	assign after_cur = (rd_start < cur_start_q) ||
	                   ((rd_start == cur_start_q) && (rd_idx_s1 > cur_idx_q));
	assign elig      = first_q || (after_cur && (rd_finish <= cur_start_q));
	assign take      = rd_vld_s1 && elig && (!found_q || (rd_start > best_start_q));

	asl_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_ACTIVITIES)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (kept_q[IDX_W-1:0]),
		.wdata (best_idx_q),
		.raddr (top_ptr[IDX_W-1:0]),
		.rdata (stk_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_issue) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_nxt = found_q ? ST_SCAN : ST_EMIT_RD;
			end
			ST_EMIT_RD: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				state_nxt = (kept_q == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		stk_we  = 1'b0;
		strobe  = 1'b0;
		active  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd_pop = ~cmd_empty;
				active  = 1'b0;
			end
			ST_DECIDE: begin
				stk_we = found_q;
			end
			ST_EMIT: begin
				strobe = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign rd_addr                = scan_q;
	assign result.activity_number = NUM_W'(stk_rdata);
	assign result.last_selected   = (kept_q == CNT_W'(1));
	assign result.overflowed      = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			scan_q    <= '0;
			kept_q    <= '0;
			found_q   <= 1'b0;
			first_q   <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						scan_q  <= '0;
						kept_q  <= '0;
						found_q <= 1'b0;
						first_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + IDX_W'(1);
					if (take) found_q <= 1'b1;
				end
				ST_DRAIN: begin
					if (take) found_q <= 1'b1;
				end
				ST_DECIDE: begin
					if (found_q) begin
						kept_q  <= kept_q + CNT_W'(1);
						found_q <= 1'b0;
						first_q <= 1'b0;
						scan_q  <= '0;
					end
				end
				ST_EMIT: begin
					kept_q <= top_ptr;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (cmd_pop) begin
			n_q   <= CNT_W'(cmd.count);
			ovf_q <= cmd.overflow;
		end
		if (take) begin
			best_idx_q   <= rd_idx_s1;
			best_start_q <= rd_start;
		end
		if (stk_we) begin
			cur_idx_q   <= best_idx_q;
			cur_start_q <= best_start_q;
		end
	end

endmodule

>>> tb/sv/tb_activity_selection_latest_start.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_activity_selection_latest_start
// Self-checking bench for latest-start greedy activity selection. A table of
// directed sets (single activities, ties, touching intervals, a full store
// with dropped items) is followed by random sets: disjoint chains, narrow
// time ranges with many ties, full-range times, and oversized sets. Every
// result is checked in order against a local selection model or a typed-in expectation.
// ----------------------------------------------------------------------------
module tb_activity_selection_latest_start;
	import asl_pkg::*;

	localparam int          STORE_DEPTH  = MAX_ACTIVITIES_DEF;
	localparam int          RUN_ITEMS    = 120;     // random items per idle phase
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          TAIL_CYCLES  = 64;
	localparam int          REPORT_LIMIT = 10;
	localparam int          DIR_ROWS     = 16;

	typedef struct {
		item_t   it;
		int      reps;
		bit      fixed;
		result_t fixed_res;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	// tag travelling with the driven item: a typed-in expectation, if any
	logic    row_has_fixed;
	result_t row_fixed_result;

	// selection model state
	logic [FIELD_TIME_W-1:0] mdl_start  [STORE_DEPTH];
	logic [FIELD_TIME_W-1:0] mdl_finish [STORE_DEPTH];
	int                      mdl_count;
	bit                      mdl_dropped;

	result_t     pending_picks [$];
	int          mismatch_count;
	int unsigned cycle_count;
	int          sent_count;
	int          idle_pct;
	stim_row_t   dir_rows [DIR_ROWS];

	activity_selection_latest_start i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	task automatic note_error(input string what, input result_t want, input result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t %s: expected num=%0d last=%0b ovf=%0b, got num=%0d last=%0b ovf=%0b",
				$time, what, want.activity_number, want.last_selected, want.overflowed,
				got.activity_number, got.last_selected, got.overflowed);
	endtask

	// Store one accepted activity; on the final one run the greedy pass and
	// queue the kept numbers in ascending start order, or the typed-in expectation.
	task automatic select_on_accept(input item_t it, input bit fixed, input result_t fixed_res);
		bit      visited [STORE_DEPTH];
		int      kept [STORE_DEPTH];
		int      kept_n;
		int      best;
		logic [FIELD_TIME_W-1:0] boundary;
		result_t r;

		if (mdl_count < STORE_DEPTH) begin
			mdl_start[mdl_count]  = it.start_time;
			mdl_finish[mdl_count] = it.finish_time;
			mdl_count++;
		end else begin
			mdl_dropped = 1'b1;
		end
		if (!it.final_item)
			return;

		foreach (visited[i])
			visited[i] = 1'b0;
		kept_n   = 0;
		boundary = '0;
		for (int round = 0; round < mdl_count; round++) begin
			best = -1;
			// strict compare keeps the lower arrival number on equal starts
			for (int i = 0; i < mdl_count; i++)
				if (!visited[i] && (best < 0 || mdl_start[i] > mdl_start[best]))
					best = i;
			visited[best] = 1'b1;
			if (kept_n == 0 || mdl_finish[best] <= boundary) begin
				kept[kept_n] = best;
				kept_n++;
				boundary = mdl_start[best];
			end
		end

		if (fixed) begin
			pending_picks = {pending_picks, fixed_res};
		end else begin
			for (int k = kept_n - 1; k >= 0; k--) begin
				r.activity_number = NUM_W'(kept[k]);
				r.last_selected   = (k == 0);
				r.overflowed      = mdl_dropped;
				pending_picks     = {pending_picks, r};
			end
		end
		mdl_count   = 0;
		mdl_dropped = 1'b0;
	endtask

	// results are compared before the same edge's input transfer is modeled
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (strobe === 1'b1) begin
				if (pending_picks.size() == 0) begin
					note_error("unexpected result", '0, result);
				end else begin
					want = pending_picks.pop_front();
					if (result.activity_number !== want.activity_number ||
					    result.last_selected !== want.last_selected ||
					    result.overflowed !== want.overflowed)
						note_error("result mismatch", want, result);
				end
			end
			if (start && !busy)
				select_on_accept(item, row_has_fixed, row_fixed_result);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_item(input item_t it, input bit fixed, input result_t fixed_res);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start            <= 1'b1;
		item             <= it;
		row_has_fixed    <= fixed;
		row_fixed_result <= fixed_res;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic wait_all_picks();
		start <= 1'b0;
		@(posedge clk);
		while (pending_picks.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_set();
		int      n;
		int      sel;
		int      mode;
		int      j;
		int      pos;
		logic [FIELD_TIME_W-1:0] s_arr [40];
		logic [FIELD_TIME_W-1:0] f_arr [40];
		logic [FIELD_TIME_W-1:0] tmp;
		item_t   it;

		sel = $urandom_range(99);
		if (sel < 70)
			n = $urandom_range(8, 1);
		else if (sel < 85)
			n = $urandom_range(31, 9);
		else if (sel < 95)
			n = STORE_DEPTH;
		else
			n = $urandom_range(40, STORE_DEPTH + 1);   // overflow: tail dropped
		mode = $urandom_range(9);

		pos = $urandom_range(1000);
		for (int i = 0; i < n; i++) begin
			if (mode < 4) begin
				// disjoint chain: every activity is kept
				s_arr[i] = FIELD_TIME_W'(pos);
				pos      = pos + $urandom_range(800);
				f_arr[i] = FIELD_TIME_W'(pos);
				pos      = pos + $urandom_range(600);
			end else if (mode < 7) begin
				s_arr[i] = FIELD_TIME_W'($urandom_range(15));
				f_arr[i] = FIELD_TIME_W'($urandom_range(15));
			end else begin
				s_arr[i] = FIELD_TIME_W'($urandom());
				f_arr[i] = FIELD_TIME_W'($urandom());
			end
		end
		for (int i = n - 1; i > 0; i--) begin
			j        = $urandom_range(i);
			tmp      = s_arr[i];
			s_arr[i] = s_arr[j];
			s_arr[j] = tmp;
			tmp      = f_arr[i];
			f_arr[i] = f_arr[j];
			f_arr[j] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			it.start_time  = s_arr[i];
			it.finish_time = f_arr[i];
			it.final_item  = (i == n - 1);
			send_item(it, 1'b0, '0);
		end
	endtask

	initial begin
		int phase_end;

		clk              = 1'b0;
		arst_n           = 1'b0;
		start            = 1'b0;
		item             = '0;
		row_has_fixed    = 1'b0;
		row_fixed_result = '0;
		mdl_count        = 0;
		mdl_dropped      = 1'b0;
		mismatch_count   = 0;
		cycle_count      = 0;
		sent_count       = 0;
		idle_pct         = 21;

		dir_rows = '{
			// lone activities at the time extremes
			'{'{16'h0000, 16'h0000, 1'b1},  1, 1'b1, '{5'd0, 1'b1, 1'b0}},
			'{'{16'hFFFF, 16'hFFFF, 1'b1},  1, 1'b1, '{5'd0, 1'b1, 1'b0}},
			'{'{16'hFFFF, 16'h0000, 1'b1},  1, 1'b1, '{5'd0, 1'b1, 1'b0}},
			// mixed set with a tie on start 5 and a finish equal to a start
			'{'{16'd1,    16'd4,    1'b0},  1, 1'b0, '0},
			'{'{16'd3,    16'd5,    1'b0},  1, 1'b0, '0},
			'{'{16'd0,    16'd6,    1'b0},  1, 1'b0, '0},
			'{'{16'd5,    16'd7,    1'b0},  1, 1'b0, '0},
			'{'{16'd8,    16'd9,    1'b0},  1, 1'b0, '0},
			'{'{16'd5,    16'd9,    1'b1},  1, 1'b0, '0},
			// all starts equal
			'{'{16'd5,    16'd10,   1'b0},  1, 1'b0, '0},
			'{'{16'd5,    16'd6,    1'b0},  1, 1'b0, '0},
			'{'{16'd5,    16'd5,    1'b1},  1, 1'b0, '0},
			// alternating bit patterns
			'{'{16'hAAAA, 16'h5555, 1'b0},  1, 1'b0, '0},
			'{'{16'h5555, 16'hAAAA, 1'b1},  1, 1'b0, '0},
			// full store, final item itself dropped
			'{'{16'd100,  16'd200,  1'b0}, 32, 1'b0, '0},
			'{'{16'd100,  16'd200,  1'b1},  1, 1'b1, '{5'd0, 1'b1, 1'b1}}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			for (int k = 0; k < dir_rows[r].reps; k++)
				send_item(dir_rows[r].it, dir_rows[r].fixed, dir_rows[r].fixed_res);
		wait_all_picks();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct  = (phase == 0) ? 21 : (phase == 1) ? 60 : 0;
			phase_end = sent_count + RUN_ITEMS;
			while (sent_count < phase_end)
				send_random_set();
			// sender holds off until every pick is out
			wait_all_picks();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		mismatch_count += pending_picks.size();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
